// File: hdl/ttcd_pkg.sv
package ttcd_pkg;

    // line phase, one-hot
    typedef enum logic [4:0] {
        PH_CLOSED = 5'b00001,
        PH_CMD    = 5'b00010,
        PH_INST   = 5'b00100,
        PH_EXPR   = 5'b01000,
        PH_OPND   = 5'b10000
    } t_phase;

    // result event codes
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_NOTE_OFF = 4'd1;
    localparam logic [3:0] EV_NOTE_ON  = 4'd2;
    localparam logic [3:0] EV_EXPR     = 4'd3;
    localparam logic [3:0] EV_RESET    = 4'd4;
    localparam logic [3:0] EV_EOL      = 4'd5;
    localparam logic [3:0] EV_SKIPPED  = 4'd6;
    localparam logic [3:0] EV_OPENED   = 4'd7;
    localparam logic [3:0] EV_STRAY    = 4'd8;

    // request kinds
    localparam logic REQ_LINE_START = 1'b0;
    localparam logic REQ_BYTE       = 1'b1;

    // expression tags with special operand forms
    localparam logic [3:0] TAG_INV_NIBBLE = 4'd0;
    localparam logic [3:0] TAG_NIBBLE     = 4'd8;
    localparam logic [3:0] TAG_SHORT_MIN  = 4'd11;
    localparam logic [3:0] TAG_SHIFT_A    = 4'd3;
    localparam logic [3:0] TAG_SHIFT_B    = 4'd4;

    typedef struct packed {
        t_phase     phase;
        logic [4:0] skip_cnt;
        logic [4:0] expr_rem;
        logic [6:0] note;
        logic [3:0] tag;
        logic [3:0] low;
    } t_dec_state;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [6:0]  note_value;
        logic [7:0]  instrument_number;
        logic [3:0]  expr_tag;
        logic [11:0] expr_value;
        logic [4:0]  skip_lines;
    } t_dec_result;

endpackage

// File: hdl/tracker_track_command_decoder.sv
// Track command decoder for one music channel. Each input transfer is either a
// line start (tuser = 0) or one track byte (tuser = 1, byte in tdata). Every
// input transfer yields exactly one output transfer whose tuser is the event
// kind: none (a byte that only begins a multi-byte command), note off, note on
// with its instrument, expression with tag and assembled 12-bit operand,
// instrument reset, end of line with skip count, line skipped, line opened, or
// stray byte (track byte while no line is open). Fields that do not belong to
// the event read as zero. Rate: one transfer per clock in and out while the
// output is not stalled; a result appears in the cycle after its input
// transfer, from the single output register. The decode state updates in the same cycle the byte is taken, so
// bytes may follow each other on every clock, and the input side keeps
// accepting while the output is being drained.
module tracker_track_command_decoder
    import ttcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] note_value, [14:7] instrument_number, [18:15] expr_tag,
    // [30:19] expr_value, [35:31] skip_lines, [39:36] zero
    output logic [39:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser    // [3:0] event_kind
);

    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result dec_result;
    t_dec_result r_result;
    logic        r_out_valid;
    logic        in_xfer;

    // take a new transfer whenever the output slot is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ttcd_decode u_decode (
        .i_state     (r_state),
        .i_req_type  (s_axis_tuser[0]),
        .i_data_byte (s_axis_tdata),
        .o_state     (n_state),
        .o_result    (dec_result)
    );

    // decode state, held note and expression fields included
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_CLOSED;
            r_state.skip_cnt <= '0;
            r_state.expr_rem <= '0;
            r_state.note     <= '0;
            r_state.tag      <= '0;
            r_state.low      <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= dec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.event_kind;
    assign m_axis_tdata  = {4'd0, r_result.skip_lines, r_result.expr_value,
                            r_result.expr_tag, r_result.instrument_number,
                            r_result.note_value};

`ifndef SYNTH
    // a line start always leaves the line either open or closed
    a_line_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tuser[0] == REQ_LINE_START
        |=> (r_state.phase == PH_CMD || r_state.phase == PH_CLOSED))
        else $error("line start left a command in progress");

    // inside an expression group at least one command is still owed
    a_expr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_EXPR || r_state.phase == PH_OPND)
        |-> r_state.expr_rem != 5'd0)
        else $error("expression phase with empty count");

    // byte taken in instrument phase reports a note on
    a_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tuser[0] == REQ_BYTE && r_state.phase == PH_INST
        |=> m_axis_tvalid && m_axis_tuser == EV_NOTE_ON)
        else $error("instrument byte did not give note on");

    // expression fields stay zero on other events
    a_expr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != EV_EXPR
        |-> m_axis_tdata[30:15] == 16'd0)
        else $error("expression fields set on non-expression event");
`endif

endmodule

// File: hdl/ttcd_decode.sv
module ttcd_decode
    import ttcd_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output t_dec_state  o_state,
    output t_dec_result o_result
);

    logic [4:0]  rem_dec;
    logic [3:0]  byte_tag;
    logic [3:0]  byte_low;
    logic [11:0] opnd_value;

    assign rem_dec  = i_state.expr_rem - 5'd1;
    assign byte_tag = i_data_byte[7:4];
    assign byte_low = i_data_byte[3:0];

    // short 8-bit operand form also covers the shift tags 3 and 4
    always_comb begin
        if (i_state.tag >= TAG_SHORT_MIN || i_state.tag == TAG_SHIFT_A
                || i_state.tag == TAG_SHIFT_B) begin
            opnd_value = {4'd0, i_state.low, i_data_byte[7:4]};
        end else begin
            opnd_value = {i_state.low, i_data_byte};
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_req_type == REQ_LINE_START) begin
            o_state.expr_rem = '0;
            if (i_state.skip_cnt != 5'd0) begin
                o_state.skip_cnt    = i_state.skip_cnt - 5'd1;
                o_state.phase       = PH_CLOSED;
                o_result.event_kind = EV_SKIPPED;
            end else begin
                o_state.phase       = PH_CMD;
                o_result.event_kind = EV_OPENED;
            end
        end else begin
            unique case (i_state.phase)
                PH_CMD: begin
                    priority if (i_data_byte == 8'h00) begin
                        o_result.event_kind = EV_NOTE_OFF;
                    end else if (!i_data_byte[7]) begin
                        o_state.note  = i_data_byte[6:0];
                        o_state.phase = PH_INST;
                    end else if (!i_data_byte[6]) begin
                        o_state.expr_rem = {1'b0, byte_low} + 5'd1;
                        o_state.phase    = PH_EXPR;
                    end else if (!i_data_byte[5]) begin
                        o_state.skip_cnt    = i_data_byte[4:0];
                        o_state.phase       = PH_CLOSED;
                        o_result.event_kind = EV_EOL;
                        o_result.skip_lines = i_data_byte[4:0];
                    end else if (!i_data_byte[4]) begin
                        o_result.event_kind = EV_RESET;
                    end else begin
                        // end marker
                        o_state.phase       = PH_CLOSED;
                        o_result.event_kind = EV_EOL;
                    end
                end
                PH_INST: begin
                    o_state.phase              = PH_CMD;
                    o_result.event_kind        = EV_NOTE_ON;
                    o_result.note_value        = i_state.note;
                    o_result.instrument_number = i_data_byte;
                end
                PH_EXPR: begin
                    if (byte_tag == TAG_INV_NIBBLE || byte_tag == TAG_NIBBLE) begin
                        o_result.event_kind = EV_EXPR;
                        o_result.expr_tag   = byte_tag;
                        o_result.expr_value = (byte_tag == TAG_INV_NIBBLE)
                                            ? {8'd0, ~byte_low} : {8'd0, byte_low};
                        o_state.expr_rem    = rem_dec;
                        o_state.phase       = (rem_dec == 5'd0) ? PH_CMD : PH_EXPR;
                    end else begin
                        o_state.tag   = byte_tag;
                        o_state.low   = byte_low;
                        o_state.phase = PH_OPND;
                    end
                end
                PH_OPND: begin
                    o_result.event_kind = EV_EXPR;
                    o_result.expr_tag   = i_state.tag;
                    o_result.expr_value = opnd_value;
                    o_state.expr_rem    = rem_dec;
                    o_state.phase       = (rem_dec == 5'd0) ? PH_CMD : PH_EXPR;
                end
                default: begin
                    // line closed: stray byte, no state change
                    o_result.event_kind = EV_STRAY;
                end
            endcase
        end
    end

endmodule
